### src/etx_link_quality_table_core_assert.svh
// Assertion macros used by the link quality table datapath
`ifndef ETX_LINK_QUALITY_TABLE_CORE_ASSERT_SVH
`define ETX_LINK_QUALITY_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define ETX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ETX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/etx_pkg.sv
// Types and constants of the link quality table
package etx_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned HEARD_W = 16;
  localparam int unsigned FDR_W   = 7;
  localparam int unsigned PDR_W   = 17;
  localparam int unsigned ETX_W   = 16;
  localparam int unsigned WGT_W   = 9;
  localparam int unsigned PF_W    = 24;
  localparam int unsigned DIV_W   = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [PDR_W-1:0]   PDR_ONE   = 17'h10000;
  localparam logic [ETX_W-1:0]   ETX_MAX   = 16'hFFFF;
  localparam logic [FDR_W-1:0]   FDR_MAX   = 7'd100;
  localparam logic [WGT_W-1:0]   WGT_MAX   = 9'd256;
  localparam logic [DIV_W-1:0]   INV_NUM   = 32'd1677721600;
  localparam logic [HEARD_W-1:0] HEARD_MAX = 16'hFFFF;
  localparam logic [FDR_W-1:0]   PCT_FULL  = 7'd100;

  localparam logic [CFG_IDX_W-1:0] REG_EWMA_WEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ETX = 1'd1;

  localparam logic [1:0] ACT_PROBE   = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_REPORT  = 2'd2;
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  localparam logic [2:0] RK_UPDATED = 3'd0;
  localparam logic [2:0] RK_ADDED   = 3'd1;
  localparam logic [2:0] RK_DROPPED = 3'd2;
  localparam logic [2:0] RK_ETX     = 3'd3;
  localparam logic [2:0] RK_REPORT  = 3'd4;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] neighbor_addr;
    logic [SEQ_W-1:0]  seq_num;
    logic [FDR_W-1:0]  fdr_percent;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        result_kind;
    logic [ADDR_W-1:0] entry_addr;
    logic [FDR_W-1:0]  pdr_percent;
    logic [ETX_W-1:0]  etx_value;
    logic              last;
  } res_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [SEQ_W-1:0]   first_seq;
    logic [SEQ_W-1:0]   last_seq;
    logic [HEARD_W-1:0] heard;
    logic [FDR_W-1:0]   fdr;
    logic [PDR_W-1:0]   pdr;
    logic [ETX_W-1:0]   etx;
  } entry_t;

  typedef enum logic [2:0] {
    RS_UPD, RS_ADD, RS_DROP, RS_TICK, RS_REP, RS_EMPTY
  } res_src_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_P_RD, ST_P_CMP, ST_P_DECIDE, ST_T_RD, ST_T_CHK, ST_T_DIV1,
    ST_T_PF, ST_T_INV, ST_T_DIV2, ST_T_EWMA, ST_T_WB, ST_R_RD, ST_R_RES, ST_EMIT
  } state_e;

  typedef struct packed {
    logic     latch_in;
    logic     idx_clr;
    logic     idx_inc;
    logic     rd_idx;
    logic     rd_rep;
    logic     wr_upd;
    logic     wr_new;
    logic     wr_tick;
    logic     div_start1;
    logic     div_start2;
    logic     cap_keep;
    logic     cap_pdr;
    logic     cap_pf;
    logic     cap_inv;
    logic     cap_inv_max;
    logic     cap_etx;
    logic     res_load;
    res_src_e res_src;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_action;
    logic [1:0] cur_action;
    logic       cnt_zero;
    logic       full;
    logic       match;
    logic       idx_last;
    logic       span_zero;
    logic       pf_zero;
    logic       div_done;
    logic       out_free;
  } status_t;

endpackage

### src/etx_div.sv
// Restoring divider, one quotient bit per cycle
module etx_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [etx_pkg::DIV_W-1:0] dividend_i,
  input  logic [etx_pkg::DIV_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [etx_pkg::DIV_W-1:0] quotient_o
);
  localparam int unsigned DW  = etx_pkg::DIV_W;
  localparam int unsigned SCW = $clog2(DW + 1);

  logic [SCW-1:0] step_q;
  logic           busy_q, done_q;
  logic [DW-1:0]  dvd_q, dsr_q, rem_q;
  logic [DW:0]    trial;
  logic           ge;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= SCW'(DW);
    end else if (busy_q) begin
      step_q <= step_q - SCW'(1);
      if (step_q == SCW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= DW'(trial - {1'b0, dsr_q});
      end else begin
        rem_q <= trial[DW-1:0];
      end
      dvd_q <= {dvd_q[DW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = dvd_q;
endmodule

### src/etx_ctrl.sv
// Sequencer for probe, window tick and report handling
module etx_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  etx_pkg::status_t st_i,
  output etx_pkg::cmd_t    cmd_o
);
  etx_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= etx_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      etx_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (st_i.in_action == etx_pkg::ACT_PROBE) state_d = etx_pkg::ST_P_RD;
          else if (st_i.in_action == etx_pkg::ACT_TICK) state_d = etx_pkg::ST_T_RD;
          else if (st_i.in_action == etx_pkg::ACT_REPORT) state_d = etx_pkg::ST_R_RD;
        end
      end
      etx_pkg::ST_P_RD:
        state_d = st_i.cnt_zero ? etx_pkg::ST_P_DECIDE : etx_pkg::ST_P_CMP;
      etx_pkg::ST_P_CMP: begin
        if (st_i.match) state_d = etx_pkg::ST_EMIT;
        else if (st_i.idx_last) state_d = etx_pkg::ST_P_DECIDE;
        else state_d = etx_pkg::ST_P_RD;
      end
      etx_pkg::ST_P_DECIDE: state_d = etx_pkg::ST_EMIT;
      etx_pkg::ST_T_RD:
        state_d = st_i.cnt_zero ? etx_pkg::ST_IDLE : etx_pkg::ST_T_CHK;
      etx_pkg::ST_T_CHK:
        state_d = st_i.span_zero ? etx_pkg::ST_T_WB : etx_pkg::ST_T_DIV1;
      etx_pkg::ST_T_DIV1: if (st_i.div_done) state_d = etx_pkg::ST_T_PF;
      etx_pkg::ST_T_PF: state_d = etx_pkg::ST_T_INV;
      etx_pkg::ST_T_INV:
        state_d = st_i.pf_zero ? etx_pkg::ST_T_EWMA : etx_pkg::ST_T_DIV2;
      etx_pkg::ST_T_DIV2: if (st_i.div_done) state_d = etx_pkg::ST_T_EWMA;
      etx_pkg::ST_T_EWMA: state_d = etx_pkg::ST_T_WB;
      etx_pkg::ST_T_WB: state_d = etx_pkg::ST_EMIT;
      etx_pkg::ST_R_RD:
        state_d = st_i.cnt_zero ? etx_pkg::ST_EMIT : etx_pkg::ST_R_RES;
      etx_pkg::ST_R_RES: state_d = etx_pkg::ST_EMIT;
      etx_pkg::ST_EMIT: begin
        if (st_i.out_free) begin
          if (st_i.cur_action == etx_pkg::ACT_TICK && !st_i.idx_last) begin
            state_d = etx_pkg::ST_T_RD;
          end else begin
            state_d = etx_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = etx_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.res_src = etx_pkg::RS_UPD;
    unique case (state_q)
      etx_pkg::ST_IDLE: begin
        cmd_o.latch_in = in_valid_i;
        cmd_o.idx_clr  = in_valid_i;
      end
      etx_pkg::ST_P_RD: cmd_o.rd_idx = !st_i.cnt_zero;
      etx_pkg::ST_P_CMP: begin
        if (st_i.match) begin
          cmd_o.wr_upd   = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_src  = etx_pkg::RS_UPD;
        end else if (!st_i.idx_last) begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      etx_pkg::ST_P_DECIDE: begin
        cmd_o.res_load = 1'b1;
        if (st_i.full) begin
          cmd_o.res_src = etx_pkg::RS_DROP;
        end else begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.res_src = etx_pkg::RS_ADD;
        end
      end
      etx_pkg::ST_T_RD: cmd_o.rd_idx = !st_i.cnt_zero;
      etx_pkg::ST_T_CHK: begin
        cmd_o.cap_keep   = st_i.span_zero;
        cmd_o.div_start1 = !st_i.span_zero;
      end
      etx_pkg::ST_T_DIV1: cmd_o.cap_pdr = st_i.div_done;
      etx_pkg::ST_T_PF: cmd_o.cap_pf = 1'b1;
      etx_pkg::ST_T_INV: begin
        cmd_o.cap_inv_max = st_i.pf_zero;
        cmd_o.div_start2  = !st_i.pf_zero;
      end
      etx_pkg::ST_T_DIV2: cmd_o.cap_inv = st_i.div_done;
      etx_pkg::ST_T_EWMA: cmd_o.cap_etx = 1'b1;
      etx_pkg::ST_T_WB: begin
        cmd_o.wr_tick  = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_src  = etx_pkg::RS_TICK;
      end
      etx_pkg::ST_R_RD: begin
        if (st_i.cnt_zero) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_src  = etx_pkg::RS_EMPTY;
        end else begin
          cmd_o.rd_rep = 1'b1;
        end
      end
      etx_pkg::ST_R_RES: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_src  = etx_pkg::RS_REP;
      end
      etx_pkg::ST_EMIT: begin
        cmd_o.out_load = st_i.out_free;
        cmd_o.idx_inc  = st_i.out_free && st_i.cur_action == etx_pkg::ACT_TICK
                         && !st_i.idx_last;
      end
      default: cmd_o.res_src = etx_pkg::RS_UPD;
    endcase
  end

  assign in_ready_o = state_q == etx_pkg::ST_IDLE;
endmodule

### src/etx_dp.sv
// Table memory, arithmetic and output register of the link quality table
`include "etx_link_quality_table_core_assert.svh"
module etx_dp #(
  parameter int unsigned TABLE_DEPTH = etx_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  etx_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output etx_pkg::res_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [etx_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [etx_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  etx_pkg::cmd_t                 cmd_i,
  output etx_pkg::status_t              st_o
);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DW    = etx_pkg::DIV_W;
  localparam int unsigned EW    = etx_pkg::ETX_W;
  localparam int unsigned PW    = etx_pkg::PDR_W;

  etx_pkg::entry_t mem [TABLE_DEPTH];

  logic [etx_pkg::WGT_W-1:0] wgt_q;
  logic [EW-1:0]             init_etx_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [IDX_W-1:0]          idx_q, ptr_q;
  etx_pkg::in_item_t         item_q;
  etx_pkg::entry_t           rd_q, wdata;
  logic [PW-1:0]             pdr_new_q;
  logic [EW-1:0]             etx_new_q, inv_q;
  logic [etx_pkg::PF_W-1:0]  pf_q;
  etx_pkg::res_item_t        res_q, res_d, out_q;
  logic                      out_valid_q;

  logic                      full, idx_last, out_free, wr_en;
  logic [IDX_W-1:0]          waddr, rep_idx, rep_next;
  logic [etx_pkg::SEQ_W-1:0] span;
  logic                      div_start, div_busy, div_done;
  logic [DW-1:0]             div_dvd, div_dsr, div_q;
  logic [etx_pkg::WGT_W-1:0] wgt;
  logic [24:0]               ewma;
  logic [etx_pkg::FDR_W-1:0] fdr_in;

  function automatic logic [etx_pkg::FDR_W-1:0] pct_of(input logic [PW-1:0] p);
    logic [23:0] prod;
    prod = 24'(p) * 24'd100;
    return prod[22:16];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wgt_q      <= '0;
      init_etx_q <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        etx_pkg::REG_EWMA_WEIGHT: wgt_q <= cfg_wdata_i[etx_pkg::WGT_W-1:0];
        etx_pkg::REG_INITIAL_ETX: init_etx_q <= cfg_wdata_i;
        default: wgt_q <= wgt_q;
      endcase
    end
  end

  assign full     = cnt_q == CNT_W'(TABLE_DEPTH);
  assign idx_last = CNT_W'(CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign span     = rd_q.last_seq - rd_q.first_seq;
  assign rep_idx  = (CNT_W'(ptr_q) >= cnt_q) ? '0 : ptr_q;
  assign rep_next = (CNT_W'(CNT_W'(rep_idx) + CNT_W'(1)) >= cnt_q) ? '0
                    : IDX_W'(rep_idx + IDX_W'(1));
  assign fdr_in   = (in_data_i.fdr_percent > etx_pkg::FDR_MAX) ? etx_pkg::FDR_MAX
                    : in_data_i.fdr_percent;
  assign wgt      = (wgt_q > etx_pkg::WGT_MAX) ? etx_pkg::WGT_MAX : wgt_q;
  assign ewma     = 25'(wgt) * 25'(rd_q.etx) + 25'(etx_pkg::WGT_MAX - wgt) * 25'(inv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.wr_new) cnt_q <= CNT_W'(cnt_q + CNT_W'(1));
      if (cmd_i.rd_rep) ptr_q <= rep_next;
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= IDX_W'(idx_q + IDX_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      item_q <= '{action: in_data_i.action, neighbor_addr: in_data_i.neighbor_addr,
                  seq_num: in_data_i.seq_num, fdr_percent: fdr_in};
    end
    if (cmd_i.cap_keep) begin
      pdr_new_q <= rd_q.pdr;
      etx_new_q <= rd_q.etx;
    end
    if (cmd_i.cap_pdr) pdr_new_q <= (div_q > DW'(etx_pkg::PDR_ONE)) ? etx_pkg::PDR_ONE
                                    : div_q[PW-1:0];
    if (cmd_i.cap_pf) pf_q <= etx_pkg::PF_W'(pdr_new_q) * etx_pkg::PF_W'(rd_q.fdr);
    if (cmd_i.cap_inv_max) inv_q <= etx_pkg::ETX_MAX;
    else if (cmd_i.cap_inv) inv_q <= (div_q > DW'(etx_pkg::ETX_MAX)) ? etx_pkg::ETX_MAX
                                     : div_q[EW-1:0];
    if (cmd_i.cap_etx) etx_new_q <= ewma[23:8];
    if (cmd_i.res_load) res_q <= res_d;
  end

  always_comb begin
    wdata = rd_q;
    waddr = idx_q;
    wr_en = cmd_i.wr_upd || cmd_i.wr_new || cmd_i.wr_tick;
    if (cmd_i.wr_new) begin
      waddr           = cnt_q[IDX_W-1:0];
      wdata.addr      = item_q.neighbor_addr;
      wdata.first_seq = item_q.seq_num;
      wdata.last_seq  = item_q.seq_num;
      wdata.heard     = etx_pkg::HEARD_W'(1);
      wdata.fdr       = item_q.fdr_percent;
      wdata.pdr       = etx_pkg::PDR_ONE;
      wdata.etx       = init_etx_q;
    end else if (cmd_i.wr_upd) begin
      wdata.last_seq = item_q.seq_num;
      wdata.fdr      = item_q.fdr_percent;
      if (rd_q.heard != etx_pkg::HEARD_MAX) begin
        wdata.heard = etx_pkg::HEARD_W'(rd_q.heard + etx_pkg::HEARD_W'(1));
      end
    end else begin
      wdata.first_seq = rd_q.last_seq;
      wdata.heard     = '0;
      wdata.pdr       = pdr_new_q;
      wdata.etx       = etx_new_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= wdata;
    if (cmd_i.rd_idx) rd_q <= mem[idx_q];
    else if (cmd_i.rd_rep) rd_q <= mem[rep_idx];
  end

  always_comb begin
    res_d.entry_addr = rd_q.addr;
    res_d.last       = 1'b1;
    case (cmd_i.res_src)
      etx_pkg::RS_UPD: begin
        res_d.result_kind = etx_pkg::RK_UPDATED;
        res_d.pdr_percent = pct_of(rd_q.pdr);
        res_d.etx_value   = rd_q.etx;
      end
      etx_pkg::RS_ADD: begin
        res_d.result_kind = etx_pkg::RK_ADDED;
        res_d.entry_addr  = item_q.neighbor_addr;
        res_d.pdr_percent = etx_pkg::PCT_FULL;
        res_d.etx_value   = init_etx_q;
      end
      etx_pkg::RS_DROP: begin
        res_d.result_kind = etx_pkg::RK_DROPPED;
        res_d.entry_addr  = item_q.neighbor_addr;
        res_d.pdr_percent = '0;
        res_d.etx_value   = '0;
      end
      etx_pkg::RS_TICK: begin
        res_d.result_kind = etx_pkg::RK_ETX;
        res_d.pdr_percent = pct_of(pdr_new_q);
        res_d.etx_value   = etx_new_q;
        res_d.last        = idx_last;
      end
      etx_pkg::RS_REP: begin
        res_d.result_kind = etx_pkg::RK_REPORT;
        res_d.pdr_percent = pct_of(rd_q.pdr);
        res_d.etx_value   = rd_q.etx;
      end
      default: begin
        res_d.result_kind = etx_pkg::RK_REPORT;
        res_d.entry_addr  = '0;
        res_d.pdr_percent = etx_pkg::PCT_FULL;
        res_d.etx_value   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign div_start = cmd_i.div_start1 || cmd_i.div_start2;
  assign div_dvd   = cmd_i.div_start1 ? {rd_q.heard, 16'h0} : etx_pkg::INV_NUM;
  assign div_dsr   = cmd_i.div_start1 ? span : DW'(pf_q);

  etx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign st_o.in_action  = in_data_i.action;
  assign st_o.cur_action = item_q.action;
  assign st_o.cnt_zero   = cnt_q == '0;
  assign st_o.full       = full;
  assign st_o.match      = rd_q.addr == item_q.neighbor_addr;
  assign st_o.idx_last   = idx_last;
  assign st_o.span_zero  = span == '0;
  assign st_o.pf_zero    = pf_q == '0;
  assign st_o.div_done   = div_done;
  assign st_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ETX_ASSERT_NOW(a_new_not_full, cmd_i.wr_new, !full, "append into a full table")
  `ETX_ASSERT_NOW(a_div_idle, div_start, !div_busy, "divider restarted while busy")
  `ETX_ASSERT_NOW(a_out_free, cmd_i.out_load, out_free, "result overwrote a pending transfer")
  `ETX_ASSERT_NEXT(a_cnt_hold, !cmd_i.wr_new, cnt_q == $past(cnt_q), "entry count moved")
endmodule

### src/etx_link_quality_table_core.sv
// Top level of the neighbor link quality table with ETX estimator
// Probe: entries compared in turn; a match is updated, else the neighbor is added or dropped.
// Report: the entry at the report pointer, or an empty record. Tick: two passes of the shared
// divider per entry; second skipped on a zero inverse divisor, both on a zero sequence span.
// One item at a time; the next is taken the cycle after its last result is registered.
// Reset clears entry count, report pointer and control registers; table contents stay undefined.
module etx_link_quality_table_core #(
  parameter int unsigned TABLE_DEPTH = etx_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  etx_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output etx_pkg::res_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [etx_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [etx_pkg::CFG_W-1:0]     cfg_wdata_i
);
  etx_pkg::cmd_t    cmd;
  etx_pkg::status_t st;

  etx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  etx_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .st_o        (st)
  );
endmodule
